[hdl/socc_pkg.sv]
// Shared types and constants for the subarray OR coverage counter.
package socc_pkg;

  localparam int MASK_BITS_DEF = 16;
  localparam int WORD_W        = 16;
  localparam int COUNT_W       = 16;
  localparam int EPOCH_W       = 8;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              end_of_seq;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] distinct_count;
    logic               final_res;
  } out_item_t;

  typedef struct packed {
    logic probe;
    logic close;
  } seen_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } socc_state_e;

endpackage

[hdl/socc_seen_map.sv]
// Seen-value bitmap memory with epoch tags, clearing sweep and running count.
module socc_seen_map import socc_pkg::*; #(
  parameter int MASK_BITS = MASK_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  seen_ctl_t            ctl_i,
  input  logic [MASK_BITS-1:0] probe_val_i,
  output logic [COUNT_W-1:0]   count_o,
  output logic                 busy_o
);

  localparam int DEPTH = 2 ** MASK_BITS;

  logic [EPOCH_W-1:0]   seen_mem [DEPTH];
  logic [EPOCH_W-1:0]   rdata_q;
  logic                 b_vld_q;
  logic [MASK_BITS-1:0] b_val_q;
  logic [EPOCH_W-1:0]   epoch_q;
  logic                 clr_q;
  logic [MASK_BITS-1:0] clr_addr_q;
  logic [COUNT_W-1:0]   count_q;

  logic                 hit;
  logic                 we;
  logic [MASK_BITS-1:0] waddr;
  logic [EPOCH_W-1:0]   wdata;

  assign hit   = b_vld_q && (b_val_q != '0) && (rdata_q != epoch_q);
  assign we    = clr_q || hit;
  assign waddr = clr_q ? clr_addr_q : b_val_q;
  assign wdata = clr_q ? '0 : epoch_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      seen_mem[waddr] <= wdata;
    end
    rdata_q <= seen_mem[probe_val_i];
    b_val_q <= probe_val_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q    <= 1'b0;
      epoch_q    <= '0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      count_q    <= '0;
    end else begin
      b_vld_q <= ctl_i.probe;
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == '1) begin
          clr_q   <= 1'b0;
          epoch_q <= EPOCH_W'(1);
        end
      end
      if (hit && (count_q != '1)) begin
        count_q <= count_q + 1'b1;
      end
      if (ctl_i.close) begin
        count_q <= '0;
        if (epoch_q == '1) begin
          clr_q      <= 1'b1;
          clr_addr_q <= '0;
        end else begin
          epoch_q <= epoch_q + 1'b1;
        end
      end
    end
  end

  assign count_o = count_q;
  assign busy_o  = clr_q;

  a_no_probe_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.probe && clr_q))
    else $error("probe during clearing sweep");

  a_close_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.close && b_vld_q))
    else $error("close while a bitmap update is pending");

  a_epoch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_q |-> epoch_q != '0)
    else $error("reserved epoch in use");

endmodule

[hdl/subarray_or_coverage_counter_core.sv]
// Top level of the subarray OR coverage counter.
// Each transfer carries one word; the block answers with one transfer holding the number
// of distinct nonzero OR values of runs ending at any word so far, and final_res set on the
// word that closes the sequence, after which the count and the bitmap start over. For each
// item the block walks the L run-OR values left by the previous word (at most MASK_BITS+1)
// in the OR-value memory, one entry per cycle, feeding a read-modify-write of the bitmap
// memory. The next word is taken while the previous result still waits on the output
// register. After reset, and after every 255th closed sequence, the bitmap memory is
// swept over all 2^MASK_BITS entries, during which the input is stalled.
module subarray_or_coverage_counter_core import socc_pkg::*; #(
  parameter int MASK_BITS = MASK_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int IDX_W = $clog2(MASK_BITS + 1);
  localparam int CNT_W = $clog2(MASK_BITS + 2);
  localparam logic [CNT_W-1:0] LIST_DEPTH = CNT_W'(MASK_BITS + 1);

  socc_state_e state_q, state_d;

  logic [MASK_BITS-1:0] or_mem [2 ** (IDX_W + 1)];
  logic [MASK_BITS-1:0] or_rdata_q;
  logic [IDX_W:0]       or_raddr;
  logic [IDX_W:0]       or_waddr;

  logic [MASK_BITS-1:0] w_q;
  logic                 last_q;
  logic [MASK_BITS-1:0] prev_q;
  logic [CNT_W-1:0]     c_q;
  logic [CNT_W-1:0]     n_q;
  logic [CNT_W-1:0]     len_q;
  logic                 bank_q;
  logic                 out_vld_q;
  out_item_t            out_q;

  logic [WORD_W+MASK_BITS-1:0] word_ext;
  logic [MASK_BITS-1:0]        w_in;
  logic [MASK_BITS-1:0]        cand;
  logic                        accept;
  logic                        append;
  logic                        out_free;
  logic                        load_out;
  logic                        walk_end;
  seen_ctl_t                   seen_ctl;
  logic [COUNT_W-1:0]          seen_count;
  logic                        seen_busy;

  assign word_ext = {{MASK_BITS{1'b0}}, in_data_i.word};
  assign w_in     = word_ext[MASK_BITS-1:0];
  assign cand     = (c_q == '0) ? w_q : (or_rdata_q | w_q);
  assign or_raddr = {bank_q, c_q[IDX_W-1:0]};
  assign or_waddr = {~bank_q, n_q[IDX_W-1:0]};

  always_comb begin
    in_stall_o    = (state_q != ST_IDLE) || seen_busy;
    accept        = in_valid_i && !in_stall_o;
    walk_end      = (c_q == len_q);
    append        = (state_q == ST_WALK) && ((c_q == '0) || (cand != prev_q))
                    && (n_q < LIST_DEPTH);
    out_free      = !out_vld_q || !out_stall_i;
    load_out      = (state_q == ST_DONE) && out_free;
    seen_ctl.probe = append;
    seen_ctl.close = load_out && last_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_WALK;
      ST_WALK:  if (walk_end) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (append) begin
      or_mem[or_waddr] <= cand;
    end
    or_rdata_q <= or_mem[or_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      w_q    <= w_in;
      last_q <= in_data_i.end_of_seq;
    end
    if (append) begin
      prev_q <= cand;
    end
    if (load_out) begin
      out_q.distinct_count <= seen_count;
      out_q.final_res      <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      c_q       <= '0;
      n_q       <= '0;
      len_q     <= '0;
      bank_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        c_q <= '0;
        n_q <= '0;
      end else if (state_q == ST_WALK) begin
        c_q <= c_q + 1'b1;
      end
      if (append) begin
        n_q <= n_q + 1'b1;
      end
      if (load_out) begin
        len_q  <= last_q ? '0 : n_q;
        bank_q <= ~bank_q;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  socc_seen_map #(
    .MASK_BITS(MASK_BITS)
  ) u_seen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (seen_ctl),
    .probe_val_i (cand),
    .count_o     (seen_count),
    .busy_o      (seen_busy)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_list_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= LIST_DEPTH)
    else $error("OR list overflow");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> c_q <= len_q)
    else $error("walk ran past stored list");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && last_q |=> len_q == '0 && state_q == ST_IDLE)
    else $error("list not cleared at sequence end");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for the subarray OR coverage counter: directed and random sequences vs a predictor.
module tb_top;
  import socc_pkg::*;

  localparam int KEY_BITS    = MASK_BITS_DEF;
  localparam int RUN_DEPTH   = KEY_BITS + 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [WORD_W-1:0]  KEY_MASK  = {WORD_W{1'b1}} >> (WORD_W - KEY_BITS);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  bit                 seen_or [0:(1 << KEY_BITS) - 1];
  logic [WORD_W-1:0]  marked_q [$];
  logic [WORD_W-1:0]  run_or [RUN_DEPTH];
  int                 run_or_len;
  logic [COUNT_W-1:0] cover_count = '0;
  out_item_t          expected_q [$];
  out_item_t          due;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  int                 holdoff_left;
  int                 errors;
  int                 cycles;

  subarray_or_coverage_counter_core #(.MASK_BITS(KEY_BITS)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  function automatic out_item_t accumulate_word(input in_item_t item);
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] v;
    logic [WORD_W-1:0] fresh [RUN_DEPTH];
    int                n;
    out_item_t         res;
    w        = item.word & KEY_MASK;
    fresh[0] = w;
    n        = 1;
    for (int i = 0; i < run_or_len; i++) begin
      v = run_or[i] | w;
      if (fresh[n-1] != v && n < RUN_DEPTH) begin
        fresh[n] = v;
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      run_or[i] = fresh[i];
      if (fresh[i] != '0 && !seen_or[fresh[i]]) begin
        seen_or[fresh[i]] = 1'b1;
        marked_q.insert(marked_q.size(), fresh[i]);
        if (cover_count != COUNT_MAX) cover_count++;
      end
    end
    run_or_len         = n;
    res.distinct_count = cover_count;
    res.final_res      = item.end_of_seq;
    if (item.end_of_seq) begin
      foreach (marked_q[j]) seen_or[marked_q[j]] = 1'b0;
      marked_q.delete();
      run_or_len  = 0;
      cover_count = '0;
    end
    return res;
  endfunction

  initial begin
    forever begin
      @(posedge clk_i);
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected transfer: distinct_count %0d final_res %0b",
               out_data_o.distinct_count, out_data_o.final_res);
        errors++;
      end else begin
        due = expected_q.pop_front();
        if (out_data_o.distinct_count !== due.distinct_count) begin
          $error("distinct_count: expected %0d, actual %0d",
                 due.distinct_count, out_data_o.distinct_count);
          errors++;
        end
        if (out_data_o.final_res !== due.final_res) begin
          $error("final_res: expected %0b, actual %0b", due.final_res, out_data_o.final_res);
          errors++;
        end
      end
    end
  end

  task automatic feed_word(input logic [WORD_W-1:0] w, input logic last);
    in_item_t item;
    item.word       = w;
    item.end_of_seq = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    expected_q.insert(expected_q.size(), accumulate_word(item));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // all ones, all zeros, zero runs ahead of nonzero words, alternating bits
  task automatic test_directed_extremes();
    feed_word(16'hFFFF, 1'b1);
    feed_word(16'h0000, 1'b0);
    feed_word(16'h0000, 1'b0);
    feed_word(16'hAAAA, 1'b0);
    feed_word(16'h5555, 1'b1);
  endtask

  // one new bit per word, then a zero word, fills the run list to its depth
  task automatic test_full_run_list();
    for (int b = 0; b < KEY_BITS; b++) feed_word(WORD_W'(1) << b, 1'b0);
    feed_word('0, 1'b0);
    feed_word(16'h8001, 1'b1);
  endtask

  task automatic test_output_holdoff();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_left   = 300;
    for (int i = 0; i < 30; i++) begin
      feed_word(WORD_W'(1) << $urandom_range(KEY_BITS - 1), i == 29);
    end
    wait_drained();
  endtask

  task automatic test_random_sequences(input int n_items);
    int                sent;
    int                len;
    int                style;
    logic [WORD_W-1:0] w;
    sent = 0;
    while (sent < n_items) begin
      style = $urandom_range(3);
      len   = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 40);
      for (int i = 0; i < len; i++) begin
        case (style)
          0: w = ($urandom_range(7) == 0) ? '0 : WORD_W'(1) << $urandom_range(WORD_W - 1);
          1: w = (WORD_W'(1) << $urandom_range(WORD_W - 1)) |
                 (WORD_W'(1) << $urandom_range(WORD_W - 1));
          2: w = WORD_W'($urandom);
          default: w = WORD_W'($urandom & $urandom & $urandom);
        endcase
        feed_word(w, i == len - 1);
      end
      sent += len;
    end
    wait_drained();
  endtask

  // enough closed sequences to pass the periodic bitmap sweep
  task automatic test_sequence_wrap();
    for (int i = 0; i < 260; i++) begin
      feed_word(($urandom_range(9) == 0) ? '0 : WORD_W'($urandom), 1'b1);
    end
    wait_drained();
  endtask

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_extremes();
    test_full_run_list();
    wait_drained();
    test_output_holdoff();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_sequences(65);
    send_idle_pct  = 81;
    recv_stall_pct = 0;
    test_random_sequences(65);
    send_idle_pct  = 0;
    recv_stall_pct = 81;
    test_random_sequences(65);
    send_idle_pct  = 31;
    recv_stall_pct = 31;
    test_random_sequences(65);
    test_sequence_wrap();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (4 * RUN_DEPTH) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/socc_pkg.sv
hdl/socc_seen_map.sv
hdl/subarray_or_coverage_counter_core.sv
verif/tb_top.sv
